@@ hw/rtl/ssi_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_pkg
// Types and widths shared by the segment crossing pipeline.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 32;

    localparam int DW   = COORD_BITS + 1;      // endpoint difference
    localparam int PW   = 2 * DW;              // product of two differences
    localparam int NW   = PW + 1;              // cross product
    localparam int BW   = COORD_BITS + NW;     // base * den
    localparam int TW   = NW + DW;             // tn * direction
    localparam int NUMW = TW + 1;              // numerator
    localparam int NSW  = NUMW + FRAC_BITS;    // scaled numerator magnitude
    localparam int QW   = COORD_BITS + FRAC_BITS;  // quotient bits
    localparam int DVW  = NW;                  // divisor magnitude

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
    } t_seg_in;

    typedef struct packed {
        logic                       hit;
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
    } t_seg_out;

    // control that rides alongside the divider lanes
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
    } t_div_ctl;

endpackage
`default_nettype wire

@@ hw/rtl/ssi_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_div
// Two-lane restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
module ssi_div
    import ssi_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire t_div_ctl         i_ctl,
    input  wire logic [NSW-1:0]   i_nx,
    input  wire logic [NSW-1:0]   i_ny,
    input  wire logic [DVW-1:0]   i_d,
    output t_div_ctl              o_ctl,
    output logic [QW-1:0]         o_qx,
    output logic [QW-1:0]         o_qy
);

    t_div_ctl         r_ctl [0:QW];
    logic [DVW-1:0]   r_d   [0:QW];
    logic [DVW-1:0]   r_rx  [0:QW];
    logic [QW-1:0]    r_lx  [0:QW];
    logic [DVW-1:0]   r_ry  [0:QW];
    logic [QW-1:0]    r_ly  [0:QW];

    logic [DVW-1:0]   n_rx  [0:QW-1];
    logic [QW-1:0]    n_lx  [0:QW-1];
    logic [DVW-1:0]   n_ry  [0:QW-1];
    logic [QW-1:0]    n_ly  [0:QW-1];

    // remainder is below the divisor before each step, so DVW+1 bits suffice
    always_comb begin
        logic [DVW:0] tx;
        logic [DVW:0] ty;
        for (int k = 0; k < QW; k++) begin
            tx = {r_rx[k], r_lx[k][QW-1]};
            ty = {r_ry[k], r_ly[k][QW-1]};
            if (tx >= {1'b0, r_d[k]}) begin
                n_rx[k] = DVW'(tx - {1'b0, r_d[k]});
                n_lx[k] = {r_lx[k][QW-2:0], 1'b1};
            end else begin
                n_rx[k] = tx[DVW-1:0];
                n_lx[k] = {r_lx[k][QW-2:0], 1'b0};
            end
            if (ty >= {1'b0, r_d[k]}) begin
                n_ry[k] = DVW'(ty - {1'b0, r_d[k]});
                n_ly[k] = {r_ly[k][QW-2:0], 1'b1};
            end else begin
                n_ry[k] = ty[DVW-1:0];
                n_ly[k] = {r_ly[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0]  <= i_d;
            r_rx[0] <= i_nx[QW+DVW-1:QW];
            r_lx[0] <= i_nx[QW-1:0];
            r_ry[0] <= i_ny[QW+DVW-1:QW];
            r_ly[0] <= i_ny[QW-1:0];
            for (int k = 0; k < QW; k++) begin
                r_d[k+1]  <= r_d[k];
                r_rx[k+1] <= n_rx[k];
                r_lx[k+1] <= n_lx[k];
                r_ry[k+1] <= n_ry[k];
                r_ly[k+1] <= n_ly[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int k = 0; k < QW; k++) begin
                r_ctl[k+1] <= r_ctl[k];
            end
        end
    end

    assign o_ctl = r_ctl[QW];
    assign o_qx  = r_lx[QW];
    assign o_qy  = r_ly[QW];

endmodule
`default_nettype wire

@@ hw/rtl/segment_segment_intersection_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// segment_segment_intersection_core
// Strict crossing test of two 2D segments with the crossing point in fixed point.
// ----------------------------------------------------------------------------
// Stages from input beat to output beat: five arithmetic stages, the divider
// input stage, one divider stage per quotient bit, one output stage.
// Throughput: one beat per cycle; the whole pipeline holds while a result
// waits at the output. Synchronous active-low reset empties the pipeline.
module segment_segment_intersection_core
    import ssi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_seg_in  i_seg,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_seg_out      o_res
);

    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_out_valid;

    // stage 1: differences
    logic signed [DW-1:0]         r1_rx, r1_ry, r1_sx, r1_sy, r1_qx, r1_qy;
    logic signed [COORD_BITS-1:0] r1_px, r1_py;
    // stage 2: products
    logic signed [PW-1:0]         r2_a, r2_b, r2_c, r2_d, r2_e, r2_f;
    logic signed [DW-1:0]         r2_rx, r2_ry;
    logic signed [COORD_BITS-1:0] r2_px, r2_py;
    // stage 3: cross products
    logic signed [NW-1:0]         r3_den, r3_tn, r3_un;
    logic signed [DW-1:0]         r3_rx, r3_ry;
    logic signed [COORD_BITS-1:0] r3_px, r3_py;
    // stage 4: hit test and numerator products
    logic signed [BW-1:0]         r4_bx, r4_by;
    logic signed [TW-1:0]         r4_tx, r4_ty;
    logic                         r4_hit, r4_dneg;
    logic [DVW-1:0]               r4_dmag;
    // stage 5: numerators
    logic signed [NUMW-1:0]       r5_nx, r5_ny;
    logic                         r5_hit, r5_dneg;
    logic [DVW-1:0]               r5_dmag;

    logic signed [NW-1:0] dp, tp, up;
    logic                 hit4;
    logic [NUMW-1:0]      magx, magy;
    t_div_ctl             div_in, div_out;
    logic [QW-1:0]        qx, qy;
    logic [QW+OUT_BITS-1:0] fx, fy;
    t_seg_out             r_res;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_out_valid <= div_out.valid;
        end
    end

    always_comb begin
        dp   = r3_den[NW-1] ? -r3_den : r3_den;
        tp   = r3_den[NW-1] ? -r3_tn  : r3_tn;
        up   = r3_den[NW-1] ? -r3_un  : r3_un;
        hit4 = (r3_den != '0) && (tp > 0) && (tp < dp) && (up > 0) && (up < dp);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_rx <= DW'(i_seg.first_end_x)    - DW'(i_seg.first_start_x);
            r1_ry <= DW'(i_seg.first_end_y)    - DW'(i_seg.first_start_y);
            r1_sx <= DW'(i_seg.second_end_x)   - DW'(i_seg.second_start_x);
            r1_sy <= DW'(i_seg.second_end_y)   - DW'(i_seg.second_start_y);
            r1_qx <= DW'(i_seg.second_start_x) - DW'(i_seg.first_start_x);
            r1_qy <= DW'(i_seg.second_start_y) - DW'(i_seg.first_start_y);
            r1_px <= i_seg.first_start_x;
            r1_py <= i_seg.first_start_y;

            r2_a  <= PW'(r1_rx) * PW'(r1_sy);
            r2_b  <= PW'(r1_ry) * PW'(r1_sx);
            r2_c  <= PW'(r1_qx) * PW'(r1_sy);
            r2_d  <= PW'(r1_qy) * PW'(r1_sx);
            r2_e  <= PW'(r1_qx) * PW'(r1_ry);
            r2_f  <= PW'(r1_qy) * PW'(r1_rx);
            r2_rx <= r1_rx;
            r2_ry <= r1_ry;
            r2_px <= r1_px;
            r2_py <= r1_py;

            r3_den <= NW'(r2_a) - NW'(r2_b);
            r3_tn  <= NW'(r2_c) - NW'(r2_d);
            r3_un  <= NW'(r2_e) - NW'(r2_f);
            r3_rx  <= r2_rx;
            r3_ry  <= r2_ry;
            r3_px  <= r2_px;
            r3_py  <= r2_py;

            r4_bx   <= BW'(r3_px) * BW'(r3_den);
            r4_by   <= BW'(r3_py) * BW'(r3_den);
            r4_tx   <= TW'(r3_tn) * TW'(r3_rx);
            r4_ty   <= TW'(r3_tn) * TW'(r3_ry);
            r4_hit  <= hit4;
            r4_dneg <= r3_den[NW-1];
            r4_dmag <= DVW'(dp);

            r5_nx   <= NUMW'(r4_bx) + NUMW'(r4_tx);
            r5_ny   <= NUMW'(r4_by) + NUMW'(r4_ty);
            r5_hit  <= r4_hit;
            r5_dneg <= r4_dneg;
            r5_dmag <= r4_dmag;
        end
    end

    always_comb begin
        magx = r5_nx[NUMW-1] ? NUMW'(-r5_nx) : NUMW'(r5_nx);
        magy = r5_ny[NUMW-1] ? NUMW'(-r5_ny) : NUMW'(r5_ny);
        div_in.valid = r_v5;
        div_in.hit   = r5_hit;
        div_in.neg_x = r5_nx[NUMW-1] ^ r5_dneg;
        div_in.neg_y = r5_ny[NUMW-1] ^ r5_dneg;
    end

    ssi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (div_in),
        .i_nx    (NSW'(magx) << FRAC_BITS),
        .i_ny    (NSW'(magy) << FRAC_BITS),
        .i_d     (r5_dmag),
        .o_ctl   (div_out),
        .o_qx    (qx),
        .o_qy    (qy)
    );

    always_comb begin
        fx = div_out.neg_x ? -(QW+OUT_BITS)'(qx) : (QW+OUT_BITS)'(qx);
        fy = div_out.neg_y ? -(QW+OUT_BITS)'(qy) : (QW+OUT_BITS)'(qy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res.hit     <= div_out.hit;
            r_res.cross_x <= div_out.hit ? fx[OUT_BITS-1:0] : '0;
            r_res.cross_y <= div_out.hit ? fy[OUT_BITS-1:0] : '0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.hit |-> o_res.cross_x == '0 && o_res.cross_y == '0)
        else $error("non-zero point on a miss");

    a_hit_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r4_hit |-> r4_dmag != '0)
        else $error("hit with zero denominator");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res))
        else $error("result lost while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready out of step with output stage");

endmodule
`default_nettype wire

@@ test/ssi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_checker
// Watches both channels of the segment crossing core, predicts each result
// from the accepted input beat and compares it with the output beats in order.
// ----------------------------------------------------------------------------
module ssi_checker
    import ssi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire logic     i_in_ready,
    input  wire t_seg_in  i_seg,
    input  wire logic     i_out_valid,
    input  wire logic     i_ready,
    input  wire t_seg_out i_res,
    output int            o_errors,
    output int            o_pending
);

    t_seg_out crossing_q[$];

    // exact truncating crossing coordinate, in wide signed integers
    function automatic logic [OUT_BITS-1:0] fixed_coord(longint base, longint den,
                                                        longint tn, longint dir);
        logic signed [127:0] num;
        logic signed [127:0] quo;
        num = (128'(signed'(base)) * 128'(signed'(den)) +
               128'(signed'(tn)) * 128'(signed'(dir))) <<< FRAC_BITS;
        quo = num / 128'(signed'(den));   // SV signed division truncates toward zero
        return quo[OUT_BITS-1:0];
    endfunction

    function automatic t_seg_out predict_crossing(t_seg_in s);
        t_seg_out r;
        longint p1x, p1y, p2x, p2y, p3x, p3y, p4x, p4y;
        longint rx, ry, sx, sy, qx, qy, den, tn, un, dp, tp, up;
        p1x = s.first_start_x;  p1y = s.first_start_y;
        p2x = s.first_end_x;    p2y = s.first_end_y;
        p3x = s.second_start_x; p3y = s.second_start_y;
        p4x = s.second_end_x;   p4y = s.second_end_y;
        rx = p2x - p1x; ry = p2y - p1y;
        sx = p4x - p3x; sy = p4y - p3y;
        qx = p3x - p1x; qy = p3y - p1y;
        den = rx * sy - ry * sx;
        tn  = qx * sy - qy * sx;
        un  = qx * ry - qy * rx;
        r = '0;
        if (den != 0) begin
            dp = den < 0 ? -den : den;
            tp = den < 0 ? -tn : tn;
            up = den < 0 ? -un : un;
            if (tp > 0 && tp < dp && up > 0 && up < dp) begin
                r.hit = 1'b1;
                r.cross_x = fixed_coord(p1x, den, tn, rx);
                r.cross_y = fixed_coord(p1y, den, tn, ry);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch %s got %0h want %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = crossing_q.size();

    always @(posedge i_clk) begin
        t_seg_out want;
        if (i_rst_n) begin
            if (i_valid && i_in_ready)
                crossing_q.push_back(predict_crossing(i_seg));
            if (i_out_valid && i_ready) begin
                if (crossing_q.size() == 0) begin
                    report_mismatch("unexpected beat", i_res.hit, 0);
                end else begin
                    want = crossing_q.pop_front();
                    if (i_res.hit !== want.hit)
                        report_mismatch("hit", i_res.hit, want.hit);
                    if (i_res.cross_x !== want.cross_x)
                        report_mismatch("cross_x", i_res.cross_x, want.cross_x);
                    if (i_res.cross_y !== want.cross_y)
                        report_mismatch("cross_y", i_res.cross_y, want.cross_y);
                end
            end
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random segment pairs into the crossing core with random
// gaps and back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import ssi_pkg::*;

    localparam int LATENCY   = 7 + COORD_BITS + FRAC_BITS;
    localparam int MAX_CYCLE = 400000;

    logic     clk, rst_n;
    logic     in_valid, in_ready, out_valid, out_ready;
    t_seg_in  seg;
    t_seg_out res;
    int       errors, pending, cycle;
    bit       calm;

    segment_segment_intersection_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_seg(seg), .o_valid(out_valid), .i_ready(out_ready), .o_res(res)
    );

    ssi_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_ready(in_ready),
        .i_seg(seg), .i_out_valid(out_valid), .i_ready(out_ready), .i_res(res),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        cycle = 0;
        forever begin
            @(posedge clk);
            cycle++;
            if (cycle > MAX_CYCLE) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= 9);
    end

    function automatic logic [COORD_BITS-1:0] rand_coord(int mode);
        case (mode)
            0: return COORD_BITS'($urandom);
            1: return COORD_BITS'($signed($urandom_range(64)) - 32);
            default: return $urandom_range(1) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    task automatic send_beat(t_seg_in s);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        seg      <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_pair(int x1, int y1, int x2, int y2,
                             int x3, int y3, int x4, int y4);
        t_seg_in s;
        s = '{COORD_BITS'(x1), COORD_BITS'(y1), COORD_BITS'(x2), COORD_BITS'(y2),
              COORD_BITS'(x3), COORD_BITS'(y3), COORD_BITS'(x4), COORD_BITS'(y4)};
        send_beat(s);
    endtask

    initial begin
        t_seg_in s;
        int mode;
        calm     = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        seg      = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_pair(0, 0, 10, 10, 0, 10, 10, 0);          // plain cross
        send_pair(0, 0, 10, 0, 0, 5, 10, 5);            // parallel
        send_pair(0, 0, 10, 0, 2, 0, 8, 0);             // collinear
        send_pair(3, 3, 3, 3, 0, 0, 9, 9);              // zero length
        send_pair(0, 0, 10, 0, 10, -5, 10, 5);          // touch at t = 1
        send_pair(0, 0, 10, 0, 0, -5, 0, 5);            // touch at t = 0
        send_pair(0, -5, 0, 5, -5, 0, 5, 0);            // cross on origin
        send_pair(0, 0, 10, 0, 5, 1, 5, 9);             // u out of range
        send_pair(0, 0, 3, 7, 0, 7, 5, -2);             // fractional point
        send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
        send_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
        send_pair(-32768, -32768, -32768, 32767, -32768, 0, 32767, 0);
        send_pair(1, 0, -1, 0, 0, 1, 0, -1);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(-1, -1, -1, -1, -1, -1, -1, -1);

        // drain before going on
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);

        for (int i = 0; i < 500; i++) begin
            calm = (i >= 200 && i < 280);
            mode = $urandom_range(9);
            if (mode < 6) begin
                // likely crossing: second segment placed around the midpoint of the first
                s.first_start_x  = rand_coord(mode % 2);
                s.first_start_y  = rand_coord(mode % 2);
                s.first_end_x    = rand_coord(mode % 2);
                s.first_end_y    = rand_coord(mode % 2);
                s.second_start_x = (s.first_start_x >>> 1) + (s.first_end_x >>> 1)
                                 + COORD_BITS'($signed($urandom_range(20)) - 10);
                s.second_start_y = (s.first_start_y >>> 1) + (s.first_end_y >>> 1)
                                 + COORD_BITS'($signed($urandom_range(200)) - 100);
                s.second_end_x   = (s.first_start_x >>> 1) + (s.first_end_x >>> 1)
                                 - COORD_BITS'($signed($urandom_range(20)) - 10);
                s.second_end_y   = (s.first_start_y >>> 1) + (s.first_end_y >>> 1)
                                 - COORD_BITS'($signed($urandom_range(200)) - 100);
            end else begin
                s.first_start_x  = rand_coord(mode % 3);
                s.first_start_y  = rand_coord(mode % 3);
                s.first_end_x    = rand_coord(mode % 3);
                s.first_end_y    = rand_coord(mode % 3);
                s.second_start_x = rand_coord(mode % 3);
                s.second_start_y = rand_coord(mode % 3);
                s.second_end_x   = rand_coord(mode % 3);
                s.second_end_y   = rand_coord(mode % 3);
            end
            send_beat(s);
            if (i == 350) begin
                // hold off until the pipeline has drained
                @(negedge clk);
                in_valid <= 1'b0;
                while (pending != 0) @(posedge clk);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ssi_pkg.sv
hw/rtl/ssi_div.sv
hw/rtl/segment_segment_intersection_core.sv
test/ssi_checker.sv
test/testbench.sv
